FILE: sv/arpc_pkg.sv
// Shared types and constants for the ARP responder with cache.
package arpc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int SLOT_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;

    localparam logic [47:0] MAC_ONES = 48'hffff_ffff_ffff;

    localparam logic [1:0] ST_DROP = 2'd0;
    localparam logic [1:0] ST_REPLY = 2'd1;
    localparam logic [1:0] ST_HIT = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_REPLY = 2'd2;

    localparam logic REG_OWN_MAC = 1'b0;
    localparam logic REG_OWN_IP = 1'b1;

    // Classified request kind passed from front to back.
    typedef enum logic [1:0] {
        K_DROP,
        K_LEARN,
        K_LEARN_REPLY,
        K_RESOLVE
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [47:0] eth_dst;
    } work_t;

endpackage

FILE: sv/arpc_front.sv
// Front part: validate and classify a request; the top level pushes it into the queue.
module arpc_front
    import arpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_idx,
    input  logic [47:0] cfg_data,
    input  logic        func,
    input  logic [15:0] hw_type,
    input  logic [7:0]  hw_len,
    input  logic [7:0]  proto_len,
    input  logic [15:0] arp_op,
    input  logic [47:0] sender_mac,
    input  logic [31:0] sender_ip,
    input  logic [47:0] target_mac,
    input  logic [31:0] target_ip,
    input  logic [47:0] frame_src_mac,
    output work_t       work
);

    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic        hdr_ok;
    logic        mac_ok;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == REG_OWN_MAC)
                own_mac_reg <= cfg_data;
            else
                own_ip_reg <= cfg_data[31:0];
        end
    end

    // Classify the request
    always_comb
    begin
        hdr_ok = (hw_type == 16'd1) && (hw_len == 8'd6) && (proto_len == 8'd4);
        mac_ok = (target_mac == own_mac_reg) || (target_mac == MAC_ONES)
            || (target_mac == '0);
        work.ip = sender_ip;
        work.mac = sender_mac;
        work.eth_dst = frame_src_mac;
        if (func)
        begin
            work.kind = K_RESOLVE;
            work.ip = target_ip;
        end
        else if (hdr_ok && mac_ok && (target_ip == own_ip_reg))
            work.kind = (arp_op == 16'd1) ? K_LEARN_REPLY : K_LEARN;
        else
            work.kind = K_DROP;
    end

endmodule

FILE: sv/arpc_queue.sv
// Short FIFO between the front and back parts.
module arpc_queue
    import arpc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output work_t pop_data
);

    work_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign full = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data = mem_reg[rd_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

endmodule

FILE: sv/arpc_back.sv
// Back part: cache lookup, learning and result build.
module arpc_back
    import arpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  work_t       work,
    output logic        done,
    output logic [1:0]  status,
    output logic [1:0]  out_op,
    output logic [47:0] out_eth_dst,
    output logic [47:0] out_target_mac,
    output logic [31:0] out_target_ip,
    output logic [47:0] resolved_mac
);

    logic [CACHE_ENTRIES-1:0] valid_reg;
    logic [31:0]              ip_reg [CACHE_ENTRIES];
    logic [47:0]              mac_reg [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] match;
    logic [CACHE_ENTRIES-1:0] free_one;
    logic [CACHE_ENTRIES-1:0] hit_one;
    logic [47:0]              hit_mac;
    logic                     learn;

    // Compare all entries at once
    always_comb
    begin
        for (int i = 0; i < CACHE_ENTRIES; i++)
            match[i] = valid_reg[i] && (ip_reg[i] == work.ip);
        hit_one = match & (~match + 1'b1);
        free_one = ~valid_reg & (valid_reg + 1'b1);
        hit_mac = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++)
            hit_mac = hit_mac | (mac_reg[i] & {48{hit_one[i]}});
        learn = go && ((work.kind == K_LEARN) || (work.kind == K_LEARN_REPLY))
            && (match == '0);
    end

    // Write cache entries
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (learn && free_one[i])
            begin
                ip_reg[i] <= work.ip;
                mac_reg[i] <= work.mac;
            end
    end

    // Hold valid bits and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done <= 1'b0;
            status <= ST_DROP;
            out_op <= OP_NONE;
            out_eth_dst <= '0;
            out_target_mac <= '0;
            out_target_ip <= '0;
            resolved_mac <= '0;
        end
        else
        begin
            if (learn)
                valid_reg <= valid_reg | free_one;
            done <= go;
            status <= ST_DROP;
            out_op <= OP_NONE;
            out_eth_dst <= '0;
            out_target_mac <= '0;
            out_target_ip <= '0;
            resolved_mac <= '0;
            unique case (work.kind)
                K_RESOLVE:
                begin
                    if (match != '0)
                    begin
                        status <= ST_HIT;
                        resolved_mac <= hit_mac;
                    end
                    else
                    begin
                        status <= ST_MISS;
                        out_op <= OP_REQUEST;
                        out_eth_dst <= MAC_ONES;
                        out_target_mac <= MAC_ONES;
                        out_target_ip <= work.ip;
                    end
                end
                K_LEARN_REPLY:
                begin
                    status <= ST_REPLY;
                    out_op <= OP_REPLY;
                    out_eth_dst <= work.eth_dst;
                    out_target_mac <= work.mac;
                    out_target_ip <= work.ip;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: sv/arp_responder_with_cache_core.sv
// Top level of the ARP responder with an IP-to-MAC cache.
//  channel   handshake              payload
//  request   start & !busy          func .. frame_src_mac
//  result    done (one cycle)       status .. resolved_mac
//  config    cfg_we                 cfg_idx, cfg_data
// A request is classified on acceptance and queued; the back part takes one
// queued request per cycle and registers its result.
// Throughput is one request per cycle; busy rises only when the queue is full.
// Reset clears the configuration, the cache valid bits and the queue.
// The receiver cannot stall: each result is shown for one cycle only.
module arp_responder_with_cache_core
    import arpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_idx,
    input  logic [47:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [15:0] hw_type,
    input  logic [7:0]  hw_len,
    input  logic [7:0]  proto_len,
    input  logic [15:0] arp_op,
    input  logic [47:0] sender_mac,
    input  logic [31:0] sender_ip,
    input  logic [47:0] target_mac,
    input  logic [31:0] target_ip,
    input  logic [47:0] frame_src_mac,
    output logic        done,
    output logic [1:0]  status,
    output logic [1:0]  out_op,
    output logic [47:0] out_eth_dst,
    output logic [47:0] out_target_mac,
    output logic [31:0] out_target_ip,
    output logic [47:0] resolved_mac
);

    work_t front_work;
    work_t back_work;
    logic  q_full;
    logic  q_ne;

    arpc_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .func(func), .hw_type(hw_type), .hw_len(hw_len),
        .proto_len(proto_len), .arp_op(arp_op), .sender_mac(sender_mac),
        .sender_ip(sender_ip), .target_mac(target_mac), .target_ip(target_ip),
        .frame_src_mac(frame_src_mac), .work(front_work)
    );

    assign busy = q_full;

    arpc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(start && !q_full), .push_data(front_work),
        .full(q_full), .pop(q_ne), .not_empty(q_ne), .pop_data(back_work)
    );

    arpc_back u_back (
        .clk(clk), .rst_n(rst_n), .go(q_ne), .work(back_work), .done(done),
        .status(status), .out_op(out_op), .out_eth_dst(out_eth_dst),
        .out_target_mac(out_target_mac), .out_target_ip(out_target_ip),
        .resolved_mac(resolved_mac)
    );

endmodule

FILE: sv/arpc_checker.sv
// Port-level checks for the ARP responder, bound to the top level.
module arpc_checker
    import arpc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [1:0]  out_op,
    input logic [47:0] out_eth_dst
);

    // A request taken from idle shows its result after the queue and the back part's result register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !$past(done) && !done && !busy) |=> ##1 done)
        else $error("result missing");

    // Opcode agrees with status
    a_op: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == ST_REPLY) == (out_op == OP_REPLY)) &&
                 ((status == ST_MISS) == (out_op == OP_REQUEST)))
        else $error("opcode mismatch");

    // A miss is broadcast
    a_bcast: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_MISS) |-> (out_eth_dst == MAC_ONES))
        else $error("miss not broadcast");

endmodule

bind arp_responder_with_cache_core arpc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .out_op(out_op), .out_eth_dst(out_eth_dst)
);
